// File: design/ole_pkg.sv
package ole_pkg;

  // command codes
  localparam logic [2:0] CMD_INS_FRONT = 3'd0;
  localparam logic [2:0] CMD_INS_END   = 3'd1;
  localparam logic [2:0] CMD_INS_POS   = 3'd2;
  localparam logic [2:0] CMD_DEL_FRONT = 3'd3;
  localparam logic [2:0] CMD_DEL_END   = 3'd4;
  localparam logic [2:0] CMD_DEL_POS   = 3'd5;
  localparam logic [2:0] CMD_SEARCH    = 3'd6;

  // status codes
  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_EMPTY    = 3'd1;
  localparam logic [2:0] ST_BADPOS   = 3'd2;
  localparam logic [2:0] ST_NOTFOUND = 3'd3;
  localparam logic [2:0] ST_FULL     = 3'd4;

  // sequencer states
  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_UP   = 4'b0010,
    S_DOWN = 4'b0100,
    S_SRCH = 4'b1000
  } state_t;

endpackage

// File: design/ordered_list_engine_top.sv
// channel  ports                                                         transfer
// -------  ------------------------------------------------------------  ---------------------
// input    start, busy, in_command, in_value, in_position                edge, start && !busy
// result   out_valid, out_status, out_found_position, out_element_count  edge ending out_valid
//
// Entries live in a single-port-write, single-port-read memory with a registered read;
// one entry is moved or compared per cycle through that read/write port pair.
// Rejected commands answer on the next cycle; busy stays high while a command runs,
// and the result strobe comes in the cycle after the last step.
// Synchronous active-low reset empties the list; memory contents are not cleared.
// Results cannot be stalled: each one is shown for exactly one cycle.
module ordered_list_engine_top #(
  parameter int DEPTH = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic [2:0]         in_command,
  input  logic signed [31:0] in_value,
  input  logic [4:0]         in_position,
  output logic               out_valid,
  output logic [2:0]         out_status,
  output logic [4:0]         out_found_position,
  output logic [4:0]         out_element_count
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam int PW = ((CW > 5) ? CW : 5) + 1;

  ole_pkg::state_t state_r, state_nxt;
  logic [CW-1:0]      count_r, count_nxt;
  logic [AW-1:0]      rd_r, rd_nxt;
  logic [AW-1:0]      stop_r, stop_nxt;
  logic [AW-1:0]      wp_addr_r, wp_addr_nxt;
  logic               rd_act_r, rd_act_nxt;
  logic               wp_r, wp_nxt;
  logic signed [31:0] val_r, val_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [2:0]         out_status_r, out_status_nxt;
  logic [4:0]         out_found_r, out_found_nxt;
  logic [4:0]         out_count_r, out_count_nxt;

  logic signed [31:0] mem [DEPTH];
  logic signed [31:0] rdata_r;
  logic               mem_we;
  logic [AW-1:0]      mem_waddr;
  logic signed [31:0] mem_wdata;

  logic               accept;
  logic               full;
  logic               empty;
  logic [PW-1:0]      cnt_p;
  logic [PW-1:0]      pos_p;
  logic [AW-1:0]      idx;
  logic [PW-1:0]      cnt_out_p;
  logic [PW-1:0]      found_p;

  assign accept = start && (state_r == ole_pkg::S_IDLE);
  assign full   = (count_r == CW'(DEPTH));
  assign empty  = (count_r == '0);
  assign cnt_p  = PW'(count_r);
  assign pos_p  = PW'(in_position);
  assign found_p = PW'(wp_addr_r) + PW'(1);

  // entry store, registered read
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rdata_r <= mem[rd_r];
  end

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    rd_nxt        = rd_r;
    stop_nxt      = stop_r;
    wp_addr_nxt   = wp_addr_r;
    rd_act_nxt    = rd_act_r;
    wp_nxt        = wp_r;
    val_nxt       = val_r;
    out_valid_nxt = 1'b0;
    out_status_nxt = out_status_r;
    out_found_nxt = out_found_r;
    out_count_nxt = out_count_r;
    mem_we        = 1'b0;
    mem_waddr     = wp_addr_r;
    mem_wdata     = rdata_r;
    idx           = '0;
    cnt_out_p     = '0;

    unique case (state_r)
      ole_pkg::S_IDLE: begin
        if (accept) begin
          val_nxt        = in_value;
          out_status_nxt = ole_pkg::ST_OK;
          out_found_nxt  = '0;
          out_count_nxt  = cnt_p[4:0];
          rd_act_nxt     = 1'b0;
          wp_nxt         = 1'b0;
          unique case (in_command)
            ole_pkg::CMD_INS_FRONT, ole_pkg::CMD_INS_END, ole_pkg::CMD_INS_POS: begin
              if (in_command == ole_pkg::CMD_INS_FRONT) begin
                idx = '0;
              end else if (in_command == ole_pkg::CMD_INS_END) begin
                idx = AW'(count_r);
              end else begin
                idx = AW'(pos_p - PW'(1));
              end
              if ((in_command == ole_pkg::CMD_INS_POS) &&
                  ((pos_p == '0) || (pos_p > cnt_p + PW'(1)))) begin
                out_status_nxt = ole_pkg::ST_BADPOS;
                out_valid_nxt  = 1'b1;
              end else if (full) begin
                out_status_nxt = ole_pkg::ST_FULL;
                out_valid_nxt  = 1'b1;
              end else begin
                // open a gap: move entries idx..count-1 up by one
                state_nxt = ole_pkg::S_UP;
                stop_nxt  = idx;
                if (CW'(idx) < count_r) begin
                  rd_act_nxt = 1'b1;
                  rd_nxt     = AW'(count_r - CW'(1));
                end
              end
            end
            ole_pkg::CMD_DEL_FRONT, ole_pkg::CMD_DEL_END, ole_pkg::CMD_DEL_POS: begin
              if (in_command == ole_pkg::CMD_DEL_FRONT) begin
                idx = '0;
              end else if (in_command == ole_pkg::CMD_DEL_END) begin
                idx = AW'(count_r - CW'(1));
              end else begin
                idx = AW'(pos_p - PW'(1));
              end
              if (empty) begin
                out_status_nxt = ole_pkg::ST_EMPTY;
                out_valid_nxt  = 1'b1;
              end else if ((in_command == ole_pkg::CMD_DEL_POS) &&
                           ((pos_p == '0) || (pos_p > cnt_p))) begin
                out_status_nxt = ole_pkg::ST_BADPOS;
                out_valid_nxt  = 1'b1;
              end else begin
                // close the gap: move entries idx+1..count-1 down by one
                state_nxt = ole_pkg::S_DOWN;
                stop_nxt  = AW'(count_r - CW'(1));
                if (CW'(idx) + CW'(1) < count_r) begin
                  rd_act_nxt = 1'b1;
                  rd_nxt     = AW'(CW'(idx) + CW'(1));
                end
              end
            end
            ole_pkg::CMD_SEARCH: begin
              if (empty) begin
                out_status_nxt = ole_pkg::ST_EMPTY;
                out_valid_nxt  = 1'b1;
              end else begin
                state_nxt  = ole_pkg::S_SRCH;
                rd_act_nxt = 1'b1;
                rd_nxt     = '0;
                stop_nxt   = AW'(count_r - CW'(1));
              end
            end
            default: begin
              out_valid_nxt = 1'b1;
            end
          endcase
        end
      end

      ole_pkg::S_UP: begin
        // write back the entry read last cycle one place higher
        if (wp_r) begin
          mem_we = 1'b1;
        end
        if (rd_act_r) begin
          wp_nxt      = 1'b1;
          wp_addr_nxt = AW'(rd_r + 1'b1);
          if (rd_r == stop_r) begin
            rd_act_nxt = 1'b0;
          end else begin
            rd_nxt = AW'(rd_r - 1'b1);
          end
        end else begin
          wp_nxt = 1'b0;
        end
        // gap is open: drop the new value in
        if (!rd_act_r && !wp_r) begin
          mem_we         = 1'b1;
          mem_waddr      = stop_r;
          mem_wdata      = val_r;
          count_nxt      = count_r + CW'(1);
          cnt_out_p      = PW'(count_r) + PW'(1);
          out_count_nxt  = cnt_out_p[4:0];
          out_valid_nxt  = 1'b1;
          state_nxt      = ole_pkg::S_IDLE;
        end
      end

      ole_pkg::S_DOWN: begin
        // write back the entry read last cycle one place lower
        if (wp_r) begin
          mem_we = 1'b1;
        end
        if (rd_act_r) begin
          wp_nxt      = 1'b1;
          wp_addr_nxt = AW'(rd_r - 1'b1);
          if (rd_r == stop_r) begin
            rd_act_nxt = 1'b0;
          end else begin
            rd_nxt = AW'(rd_r + 1'b1);
          end
        end else begin
          wp_nxt = 1'b0;
        end
        if (!rd_act_r && !wp_r) begin
          count_nxt     = count_r - CW'(1);
          cnt_out_p     = PW'(count_r) - PW'(1);
          out_count_nxt = cnt_out_p[4:0];
          out_valid_nxt = 1'b1;
          state_nxt     = ole_pkg::S_IDLE;
        end
      end

      ole_pkg::S_SRCH: begin
        // issue reads in order, compare each one in the cycle after its read
        if (rd_act_r) begin
          wp_nxt      = 1'b1;
          wp_addr_nxt = rd_r;
          if (rd_r == stop_r) begin
            rd_act_nxt = 1'b0;
          end else begin
            rd_nxt = AW'(rd_r + 1'b1);
          end
        end else begin
          wp_nxt = 1'b0;
        end
        if (wp_r && (rdata_r == val_r)) begin
          out_status_nxt = ole_pkg::ST_OK;
          out_found_nxt  = found_p[4:0];
          out_valid_nxt  = 1'b1;
          rd_act_nxt     = 1'b0;
          wp_nxt         = 1'b0;
          state_nxt      = ole_pkg::S_IDLE;
        end else if (!rd_act_r && !wp_r) begin
          out_status_nxt = ole_pkg::ST_NOTFOUND;
          out_valid_nxt  = 1'b1;
          state_nxt      = ole_pkg::S_IDLE;
        end
      end

      default: begin
        state_nxt = ole_pkg::S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ole_pkg::S_IDLE;
      count_r     <= '0;
      rd_act_r    <= 1'b0;
      wp_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      rd_act_r    <= rd_act_nxt;
      wp_r        <= wp_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    rd_r         <= rd_nxt;
    stop_r       <= stop_nxt;
    wp_addr_r    <= wp_addr_nxt;
    val_r        <= val_nxt;
    out_status_r <= out_status_nxt;
    out_found_r  <= out_found_nxt;
    out_count_r  <= out_count_nxt;
  end

  assign busy               = (state_r != ole_pkg::S_IDLE);
  assign out_valid          = out_valid_r;
  assign out_status         = out_status_r;
  assign out_found_position = out_found_r;
  assign out_element_count  = out_count_r;

endmodule

// File: dv/ole_list_checker.sv
module ole_list_checker #(
  parameter int DEPTH = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic               busy,
  input  logic [2:0]         in_command,
  input  logic signed [31:0] in_value,
  input  logic [4:0]         in_position,
  input  logic               out_valid,
  input  logic [2:0]         out_status,
  input  logic [4:0]         out_found_position,
  input  logic [4:0]         out_element_count,
  output int                 fail_count,
  output int                 outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [2:0] status;
    logic [4:0] found_position;
    logic [4:0] element_count;
  } list_result_t;

  // shadow copy of the list, packed in indexes 0..shadow_count-1
  logic [31:0]  shadow_entries [DEPTH];
  int           shadow_count;
  list_result_t pending_results [$];

  // shift the tail up by one and drop the new value into the hole
  function automatic void open_gap(input int idx, input logic [31:0] v);
    for (int i = shadow_count; i > idx; i--) begin
      shadow_entries[i] = shadow_entries[i - 1];
    end
    shadow_entries[idx] = v;
    shadow_count++;
  endfunction

  // shift the tail down over the removed entry
  function automatic void close_gap(input int idx);
    for (int i = idx; i + 1 < shadow_count; i++) begin
      shadow_entries[i] = shadow_entries[i + 1];
    end
    shadow_count--;
  endfunction

  // update the shadow list for one command and return the answer it should give
  function automatic list_result_t apply_list_command(input logic [2:0] cmd,
                                                      input logic [31:0] val,
                                                      input logic [4:0] pos);
    list_result_t r;
    int p;
    r = '0;
    r.status = ole_pkg::ST_OK;
    p = int'(pos);
    case (cmd)
      ole_pkg::CMD_INS_FRONT: begin
        if (shadow_count >= DEPTH) r.status = ole_pkg::ST_FULL;
        else open_gap(0, val);
      end
      ole_pkg::CMD_INS_END: begin
        if (shadow_count >= DEPTH) r.status = ole_pkg::ST_FULL;
        else open_gap(shadow_count, val);
      end
      ole_pkg::CMD_INS_POS: begin
        if (p == 0 || p > shadow_count + 1) r.status = ole_pkg::ST_BADPOS;
        else if (shadow_count >= DEPTH) r.status = ole_pkg::ST_FULL;
        else open_gap(p - 1, val);
      end
      ole_pkg::CMD_DEL_FRONT: begin
        if (shadow_count == 0) r.status = ole_pkg::ST_EMPTY;
        else close_gap(0);
      end
      ole_pkg::CMD_DEL_END: begin
        if (shadow_count == 0) r.status = ole_pkg::ST_EMPTY;
        else shadow_count--;
      end
      ole_pkg::CMD_DEL_POS: begin
        if (shadow_count == 0) r.status = ole_pkg::ST_EMPTY;
        else if (p == 0 || p > shadow_count) r.status = ole_pkg::ST_BADPOS;
        else close_gap(p - 1);
      end
      ole_pkg::CMD_SEARCH: begin
        if (shadow_count == 0) begin
          r.status = ole_pkg::ST_EMPTY;
        end else begin
          r.status = ole_pkg::ST_NOTFOUND;
          for (int i = 0; i < shadow_count; i++) begin
            if (r.found_position == '0 && shadow_entries[i] == val) begin
              r.status = ole_pkg::ST_OK;
              r.found_position = 5'(i + 1);
            end
          end
        end
      end
      default: ;
    endcase
    r.element_count = 5'(shadow_count);
    return r;
  endfunction

  // result transfers are checked before the same-edge command transfer is queued
  always @(posedge clk) begin : monitor
    list_result_t want;
    list_result_t seen;
    int           new_fails;
    if (!rst_n) begin
      pending_results.delete();
      shadow_count = 0;
      fail_count  <= 0;
      outstanding <= 0;
    end else begin
      new_fails = 0;
      if (out_valid) begin
        seen = {out_status, out_found_position, out_element_count};
        if (pending_results.size() == 0) begin
          $error("result transfer with nothing pending: status %0d found %0d count %0d",
                 seen.status, seen.found_position, seen.element_count);
          new_fails++;
        end else begin
          want = pending_results.pop_front();
          if (seen.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, seen.status);
            new_fails++;
          end
          if (seen.found_position !== want.found_position) begin
            $error("found_position: expected %0d, got %0d",
                   want.found_position, seen.found_position);
            new_fails++;
          end
          if (seen.element_count !== want.element_count) begin
            $error("element_count: expected %0d, got %0d",
                   want.element_count, seen.element_count);
            new_fails++;
          end
        end
      end
      if (start && !busy) begin
        pending_results.push_back(apply_list_command(in_command, in_value, in_position));
      end
      fail_count  <= fail_count + new_fails;
      outstanding <= pending_results.size();
    end
  end

endmodule

// File: dv/tb.sv
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int         DEPTH         = 16;
  localparam int         CYCLE_LIMIT   = 600000;
  localparam int         PHASE_ITEMS   = 440;
  localparam int         DRAIN_CYCLES  = 40;
  localparam logic [2:0] CMD_UNUSED    = 3'd7;
  localparam logic [31:0] VAL_MIN      = 32'h8000_0000;
  localparam logic [31:0] VAL_MAX      = 32'h7fff_ffff;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               start = 1'b0;
  logic               busy;
  logic [2:0]         in_command = '0;
  logic signed [31:0] in_value = '0;
  logic [4:0]         in_position = '0;
  logic               out_valid;
  logic [2:0]         out_status;
  logic [4:0]         out_found_position;
  logic [4:0]         out_element_count;
  int                 fail_count;
  int                 outstanding;

  int                 cycle_count = 0;
  int                 idle_pct = 0;
  int                 phase_idle [4] = '{0, 77, 0, 16};
  logic [31:0]        recent_values [8] = '{default: '0};
  int                 recent_idx = 0;

  ordered_list_engine_top #(.DEPTH(DEPTH)) u_dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .start              (start),
    .busy               (busy),
    .in_command         (in_command),
    .in_value           (in_value),
    .in_position        (in_position),
    .out_valid          (out_valid),
    .out_status         (out_status),
    .out_found_position (out_found_position),
    .out_element_count  (out_element_count)
  );

  ole_list_checker #(.DEPTH(DEPTH)) u_checker (
    .clk                (clk),
    .rst_n              (rst_n),
    .start              (start),
    .busy               (busy),
    .in_command         (in_command),
    .in_value           (in_value),
    .in_position        (in_position),
    .out_valid          (out_valid),
    .out_status         (out_status),
    .out_found_position (out_found_position),
    .out_element_count  (out_element_count),
    .fail_count         (fail_count),
    .outstanding        (outstanding)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // optional idle gap, then hold the command until the transfer edge
  task automatic send_cmd(input logic [2:0] cmd, input logic [31:0] val,
                          input logic [4:0] pos);
    int gap;
    gap = 0;
    while (idle_pct != 0 && gap < 60 && $urandom_range(99) < idle_pct) gap++;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start       <= 1'b1;
    in_command  <= cmd;
    in_value    <= val;
    in_position <= pos;
    do @(posedge clk); while (busy);
  endtask

  // let every pending result come back before going on
  task automatic drain_results();
    start <= 1'b0;
    // the pending count is a registered copy of the queue size, so it lags the last transfer
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  // random command, biased toward filling or emptying the list
  task automatic random_cmd(input bit growing);
    int          pick;
    int          vpick;
    logic [2:0]  cmd;
    logic [31:0] val;
    logic [4:0]  pos;
    pick = $urandom_range(99);
    if (pick == 0) begin
      cmd = CMD_UNUSED;
    end else if (pick < 15) begin
      cmd = ole_pkg::CMD_SEARCH;
    end else if ((pick < 80) == growing) begin
      case ($urandom_range(2))
        0:       cmd = ole_pkg::CMD_INS_FRONT;
        1:       cmd = ole_pkg::CMD_INS_END;
        default: cmd = ole_pkg::CMD_INS_POS;
      endcase
    end else begin
      case ($urandom_range(2))
        0:       cmd = ole_pkg::CMD_DEL_FRONT;
        1:       cmd = ole_pkg::CMD_DEL_END;
        default: cmd = ole_pkg::CMD_DEL_POS;
      endcase
    end
    // reuse recent values so searches hit and duplicates occur
    vpick = $urandom_range(99);
    if (vpick < 30) val = recent_values[$urandom_range(7)];
    else if (vpick < 50) val = 32'($urandom_range(7)) - 32'd3;
    else if (vpick < 56) val = $urandom_range(1) ? VAL_MIN : VAL_MAX;
    else val = $urandom();
    pos = ($urandom_range(99) < 85) ? 5'($urandom_range(18)) : 5'($urandom_range(31));
    if (cmd == ole_pkg::CMD_INS_FRONT || cmd == ole_pkg::CMD_INS_END ||
        cmd == ole_pkg::CMD_INS_POS) begin
      recent_values[recent_idx] = val;
      recent_idx = (recent_idx + 1) % 8;
    end
    send_cmd(cmd, val, pos);
  endtask

  initial begin
    bit growing;
    int run_left;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // empty list: bad positions, empty answers, unused command
    send_cmd(ole_pkg::CMD_INS_POS, 32'd5, 5'd0);
    send_cmd(ole_pkg::CMD_INS_POS, 32'd5, 5'd2);
    send_cmd(ole_pkg::CMD_SEARCH, 32'd5, 5'd0);
    send_cmd(ole_pkg::CMD_DEL_FRONT, 32'd0, 5'd0);
    send_cmd(ole_pkg::CMD_DEL_END, 32'd0, 5'd0);
    send_cmd(ole_pkg::CMD_DEL_POS, 32'd0, 5'd1);
    send_cmd(CMD_UNUSED, 32'd0, 5'd0);
    // build a short list with the extreme values
    send_cmd(ole_pkg::CMD_INS_FRONT, VAL_MIN, 5'd0);
    send_cmd(ole_pkg::CMD_INS_END, VAL_MAX, 5'd31);
    send_cmd(ole_pkg::CMD_INS_POS, 32'd0, 5'd2);
    send_cmd(ole_pkg::CMD_INS_POS, 32'hffff_ffff, 5'd4);
    send_cmd(ole_pkg::CMD_SEARCH, VAL_MAX, 5'd0);
    send_cmd(ole_pkg::CMD_SEARCH, 32'd77, 5'd0);
    send_cmd(CMD_UNUSED, VAL_MAX, 5'd31);
    // out of range positions on a non-empty list
    send_cmd(ole_pkg::CMD_DEL_POS, 32'd0, 5'd0);
    send_cmd(ole_pkg::CMD_DEL_POS, 32'd0, 5'd5);
    send_cmd(ole_pkg::CMD_DEL_POS, 32'd0, 5'd31);
    send_cmd(ole_pkg::CMD_INS_POS, 32'd9, 5'd31);
    // removals from every place
    send_cmd(ole_pkg::CMD_DEL_POS, 32'd0, 5'd2);
    send_cmd(ole_pkg::CMD_DEL_FRONT, 32'd0, 5'd0);
    send_cmd(ole_pkg::CMD_DEL_END, 32'd0, 5'd0);
    send_cmd(ole_pkg::CMD_SEARCH, VAL_MAX, 5'd0);
    drain_results();

    // random phases, with sender idling set per phase
    growing = 1'b1;
    run_left = 40;
    for (int ph = 0; ph < 4; ph++) begin
      idle_pct = phase_idle[ph];
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (run_left == 0) begin
          growing = !growing;
          run_left = $urandom_range(10, 50);
        end
        random_cmd(growing);
        run_left--;
      end
      drain_results();
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0 && outstanding == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
